>>> sv/qkd_pkg.sv
// Shared constants, codes and helpers for the quadrature knob decoder.
`default_nettype none

package qkd_pkg;

    localparam int QKD_POSITION_WIDTH = 32;
    localparam int QKD_TIME_WIDTH     = 32;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_LIST_LENGTH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MS = 1'd1;

    localparam logic [CFG_DATA_W-1:0] LIST_LENGTH_RESET = 16'd16;
    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET    = 16'd50;

    localparam logic [7:0] HIST_CCW = 8'h2b;
    localparam logic [7:0] HIST_CW  = 8'h17;

    // bit n set: transition code n is a legal Gray step
    localparam logic [15:0] CODE_VALID_MASK = 16'h6996;

    localparam logic [1:0] STEP_ZERO = 2'b00;
    localparam logic [1:0] STEP_POS  = 2'b01;
    localparam logic [1:0] STEP_NEG  = 2'b11;

    function automatic logic code_valid(input logic [3:0] code);
        return CODE_VALID_MASK[code];
    endfunction

endpackage

`default_nettype wire

>>> sv/qkd_mod_unit.sv
// Bit-serial restoring remainder unit: signed position modulo list length.
`default_nettype none

module qkd_mod_unit
    import qkd_pkg::*;
#(
    parameter int POSITION_WIDTH = QKD_POSITION_WIDTH
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire  [POSITION_WIDTH-1:0] i_value,
    input  wire  [CFG_DATA_W-1:0]     i_modulus,
    output logic                      o_done,
    output logic [CFG_DATA_W-1:0]     o_result
);

    localparam int CNT_W = $clog2(POSITION_WIDTH + 1);

    logic                      r_busy;
    logic [CNT_W-1:0]          r_cnt;
    logic [POSITION_WIDTH-1:0] r_mag;
    logic [CFG_DATA_W-1:0]     r_rem;
    logic [CFG_DATA_W-1:0]     r_len;
    logic                      r_neg;

    logic [CFG_DATA_W:0]   trial;
    logic [CFG_DATA_W:0]   trial_sub;
    logic [CFG_DATA_W-1:0] n_rem;

    // one quotient bit per cycle, magnitude MSB first
    always_comb begin
        trial     = {r_rem, r_mag[POSITION_WIDTH-1]};
        trial_sub = trial - {1'b0, r_len};
        if (trial >= {1'b0, r_len}) begin
            n_rem = trial_sub[CFG_DATA_W-1:0];
        end else begin
            n_rem = trial[CFG_DATA_W-1:0];
        end
    end

    assign o_done = r_busy && (r_cnt == '0);

    always_comb begin
        if (r_len == '0) begin
            o_result = '0;
        end else if (r_neg && (r_rem != '0)) begin
            o_result = r_len - r_rem;
        end else begin
            o_result = r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(POSITION_WIDTH);
            r_neg  <= i_value[POSITION_WIDTH-1];
            r_mag  <= i_value[POSITION_WIDTH-1] ? (~i_value + 1'b1) : i_value;
            r_rem  <= '0;
            r_len  <= i_modulus;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
                r_rem <= n_rem;
                r_mag <= {r_mag[POSITION_WIDTH-2:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/quadrature_knob_decoder_core.sv
// Top level: quadrature knob decoder with debounced push switch.
//
// Input channel (i_in_valid / o_in_stall): one sample per transaction, the two
// phase levels, the raw switch level (0 = pressed) and a free-running ms stamp.
// Output channel (o_out_valid / i_out_stall): one result per sample: detent
// step, position, position modulo list_length, and debounced button flags.
// Config port: i_cfg_we writes i_cfg_wdata to register i_cfg_index
// (0 = list_length, 1 = debounce_ms); write only while idle.
//
// The serial remainder unit, one bit a cycle over the position magnitude, sets
// the latency from input transaction to o_out_valid. No new sample is taken
// until the last result has moved into the output register. Phase and
// debounce state update in the accept cycle itself.
//
// The output register parts the two sides: the next sample is taken while a
// result still waits. If the receiver stalls longer, the finished remainder is
// parked and o_in_stall stays high until the output register frees up.
// Reset (synchronous, active low) clears all decoder state, the position, the
// debounce timer and the output valid, and restores the register defaults.
`default_nettype none

module quadrature_knob_decoder_core
    import qkd_pkg::*;
#(
    parameter int POSITION_WIDTH = QKD_POSITION_WIDTH,
    parameter int TIME_WIDTH     = QKD_TIME_WIDTH
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,

    input  wire                    i_cfg_we,
    input  wire  [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_wdata,

    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire                    i_phase_a_level,
    input  wire                    i_phase_b_level,
    input  wire                    i_switch_level,
    input  wire  [31:0]            i_now_ms,

    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output logic signed [1:0]      o_step,
    output logic signed [31:0]     o_position,
    output logic [15:0]            o_wrapped_position,
    output logic                   o_pressed,
    output logic                   o_clicked,
    output logic                   o_released
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_HOLD
    } t_state;

    // per-sample flags waiting for the remainder to finish
    typedef struct packed {
        logic [1:0] step;
        logic       clicked;
        logic       released;
    } t_result;

    t_state                    r_state;
    logic [CFG_DATA_W-1:0]     r_list_length;
    logic [CFG_DATA_W-1:0]     r_debounce;
    logic [3:0]                r_code;
    logic [7:0]                r_hist;
    logic [POSITION_WIDTH-1:0] r_pos;
    logic                      r_raw_last;
    logic [TIME_WIDTH-1:0]     r_last_change;
    logic                      r_pressed;
    t_result                   r_pend;
    logic [CFG_DATA_W-1:0]     r_wrap_pend;

    logic                      in_take;
    logic                      out_free;
    logic                      out_load;
    logic                      raw_pressed;
    logic [3:0]                n_code;
    logic                      code_ok;
    logic [7:0]                n_hist;
    logic                      step_up;
    logic                      step_dn;
    logic [POSITION_WIDTH-1:0] n_pos;
    logic [TIME_WIDTH-1:0]     now_t;
    logic [TIME_WIDTH-1:0]     n_last_change;
    logic [TIME_WIDTH-1:0]     elapsed;
    logic                      n_pressed;
    t_result                   n_pend;
    logic                      mod_done;
    logic [CFG_DATA_W-1:0]     mod_result;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_free   = !o_out_valid || !i_out_stall;
    // a finished result moves into the output register this cycle
    assign out_load   = out_free && (((r_state == S_CALC) && mod_done) || (r_state == S_HOLD));

    // phase decode: previous pair in the upper bits, B is bit 1, A bit 0
    always_comb begin
        n_code  = {r_code[1:0], i_phase_b_level, i_phase_a_level};
        code_ok = code_valid(n_code);
        n_hist  = code_ok ? {r_hist[3:0], n_code} : r_hist;
        step_dn = code_ok && (n_hist == HIST_CCW);
        step_up = code_ok && (n_hist == HIST_CW);
        if (step_up) begin
            n_pos = r_pos + 1'b1;
        end else if (step_dn) begin
            n_pos = r_pos - 1'b1;
        end else begin
            n_pos = r_pos;
        end
    end

    // debounce: a raw edge restarts the timer, so elapsed is zero that sample
    always_comb begin
        raw_pressed   = ~i_switch_level;
        now_t         = i_now_ms[TIME_WIDTH-1:0];
        n_last_change = (raw_pressed != r_raw_last) ? now_t : r_last_change;
        elapsed       = now_t - n_last_change;
        n_pressed     = (elapsed > TIME_WIDTH'(r_debounce)) ? raw_pressed : r_pressed;

        n_pend.step     = step_up ? STEP_POS : (step_dn ? STEP_NEG : STEP_ZERO);
        n_pend.clicked  = n_pressed && !r_pressed;
        n_pend.released = !n_pressed && r_pressed;
    end

    qkd_mod_unit #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_take),
        .i_value  (n_pos),
        .i_modulus(r_list_length),
        .o_done   (mod_done),
        .o_result (mod_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_list_length <= LIST_LENGTH_RESET;
            r_debounce    <= DEBOUNCE_RESET;
            r_code        <= '0;
            r_hist        <= '0;
            r_pos         <= '0;
            r_raw_last    <= 1'b0;
            r_last_change <= '0;
            r_pressed     <= 1'b0;
            o_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_LIST_LENGTH: r_list_length <= i_cfg_wdata;
                    REG_DEBOUNCE_MS: r_debounce    <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (o_out_valid && !i_out_stall && !out_load) begin
                o_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_code        <= n_code;
                        r_hist        <= n_hist;
                        r_pos         <= n_pos;
                        r_raw_last    <= raw_pressed;
                        r_last_change <= n_last_change;
                        r_pressed     <= n_pressed;
                        r_pend        <= n_pend;
                        r_state       <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (mod_done) begin
                        if (out_free) begin
                            o_out_valid        <= 1'b1;
                            o_step             <= r_pend.step;
                            o_position         <= 32'(signed'(r_pos));
                            o_wrapped_position <= mod_result;
                            o_pressed          <= r_pressed;
                            o_clicked          <= r_pend.clicked;
                            o_released         <= r_pend.released;
                            r_state            <= S_IDLE;
                        end else begin
                            r_wrap_pend <= mod_result;
                            r_state     <= S_HOLD;
                        end
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        o_out_valid        <= 1'b1;
                        o_step             <= r_pend.step;
                        o_position         <= 32'(signed'(r_pos));
                        o_wrapped_position <= r_wrap_pend;
                        o_pressed          <= r_pressed;
                        o_clicked          <= r_pend.clicked;
                        o_released         <= r_pend.released;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/qkd_checker.sv
// Port-level assertions for the knob decoder, bound to the top level.
`default_nettype none

module qkd_checker
    import qkd_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        o_in_stall,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire [1:0]  o_step,
    input wire        o_pressed,
    input wire        o_clicked,
    input wire        o_released
);

    // a result is never withdrawn while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped under stall");

    // a sample is followed by busy cycles: no two transactions back to back
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken in consecutive cycles");

    a_step_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_step == STEP_ZERO || o_step == STEP_POS || o_step == STEP_NEG))
        else $error("illegal step code");

    a_click_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_clicked && o_released))
        else $error("click and release in one result");

    // button flags agree with the debounced level they report
    a_flag_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_clicked || o_released) |-> (o_pressed == o_clicked))
        else $error("button flag disagrees with pressed state");

endmodule

bind quadrature_knob_decoder_core qkd_checker u_qkd_checker (.*);

`default_nettype wire

>>> test/tb_quadrature_knob_decoder_core.sv
// Testbench for quadrature_knob_decoder_core: directed and random samples against a scoreboard.
`timescale 1ns / 1ps

module tb_quadrature_knob_decoder_core
    import qkd_pkg::*;
();

    // Gray order of the phase pair {b, a} for clockwise rotation
    localparam logic [7:0] GRAY_SEQ = 8'b10_11_01_00;

    typedef struct packed {
        logic [1:0]  step;
        logic [31:0] position;
        logic [15:0] wrapped;
        logic        pressed;
        logic        clicked;
        logic        released;
    } t_knob_result;

    class t_knob_scoreboard;
        logic [15:0]  list_length;
        logic [15:0]  debounce_ms;
        logic [3:0]   phase_code;
        logic [7:0]   code_history;
        logic [31:0]  position_count;
        logic         raw_last;
        logic [31:0]  last_change_ms;
        logic         pressed_state;
        t_knob_result expected_q[$];
        int unsigned  failures;

        function new();
            list_length    = LIST_LENGTH_RESET;
            debounce_ms    = DEBOUNCE_RESET;
            phase_code     = '0;
            code_history   = '0;
            position_count = '0;
            raw_last       = 1'b0;
            last_change_ms = '0;
            pressed_state  = 1'b0;
            failures       = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_failure(string what);
            failures++;
            if (failures <= 10)
                $display("[%0t] ERROR %s", $realtime, what);
        endfunction

        // Predict the result of one accepted sample transaction.
        function void note_sample(logic a, logic b, logic sw, logic [31:0] now_ms);
            t_knob_result r;
            logic         raw_pressed;
            logic         next_state;
            logic [31:0]  elapsed;
            longint       pos_l;
            longint       rem;
            r = '0;
            phase_code = {phase_code[1:0], b, a};
            r.step = STEP_ZERO;
            if (CODE_VALID_MASK[phase_code]) begin
                code_history = {code_history[3:0], phase_code};
                if (code_history == HIST_CCW)
                    r.step = STEP_NEG;
                else if (code_history == HIST_CW)
                    r.step = STEP_POS;
            end
            if (r.step == STEP_POS)
                position_count = position_count + 32'd1;
            else if (r.step == STEP_NEG)
                position_count = position_count - 32'd1;

            raw_pressed = ~sw;
            if (raw_pressed != raw_last)
                last_change_ms = now_ms;
            elapsed  = now_ms - last_change_ms;   // wraps modulo 2^32
            raw_last = raw_pressed;
            next_state = (elapsed > {16'd0, debounce_ms}) ? raw_pressed : pressed_state;
            if (next_state != pressed_state) begin
                pressed_state = next_state;
                r.clicked     = next_state;
                r.released    = ~next_state;
            end

            r.position = position_count;
            r.pressed  = pressed_state;
            if (list_length != 16'd0) begin
                pos_l = $signed(position_count);
                rem   = pos_l % longint'(list_length);
                if (rem < 0)
                    rem = rem + longint'(list_length);
                r.wrapped = rem[15:0];
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(t_knob_result got);
            t_knob_result want;
            if (expected_q.size() == 0) begin
                note_failure("result transaction with no sample pending");
                return;
            end
            want = expected_q.pop_front();
            if (got.step !== want.step || got.position !== want.position ||
                got.wrapped !== want.wrapped || got.pressed !== want.pressed ||
                got.clicked !== want.clicked || got.released !== want.released)
                note_failure({
                    $sformatf("exp step=%0d pos=%0d wrap=%0d p/c/r=%b%b%b",
                        $signed(want.step), $signed(want.position), want.wrapped,
                        want.pressed, want.clicked, want.released),
                    $sformatf(", got step=%0d pos=%0d wrap=%0d p/c/r=%b%b%b",
                        $signed(got.step), $signed(got.position), got.wrapped,
                        got.pressed, got.clicked, got.released)});
        endfunction

        function void finish_check();
            if (expected_q.size() != 0)
                note_failure($sformatf("%0d expected results never arrived", expected_q.size()));
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_a      = 1'b0;
    logic                   in_b      = 1'b0;
    logic                   in_sw     = 1'b1;
    logic [31:0]            in_now    = '0;
    logic                   out_stall = 1'b0;
    logic                   quiet     = 1'b0;

    wire                    o_in_stall;
    wire                    o_out_valid;
    wire signed [1:0]       o_step;
    wire signed [31:0]      o_position;
    wire [15:0]             o_wrapped_position;
    wire                    o_pressed;
    wire                    o_clicked;
    wire                    o_released;

    t_knob_scoreboard sb;

    // stimulus generator state
    logic [1:0]  gray_idx   = 2'd0;
    logic        switch_raw = 1'b1;
    logic [31:0] stamp_ms   = '0;

    quadrature_knob_decoder_core i_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_wdata        (cfg_wdata),
        .i_in_valid         (in_valid),
        .o_in_stall         (o_in_stall),
        .i_phase_a_level    (in_a),
        .i_phase_b_level    (in_b),
        .i_switch_level     (in_sw),
        .i_now_ms           (in_now),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (out_stall),
        .o_step             (o_step),
        .o_position         (o_position),
        .o_wrapped_position (o_wrapped_position),
        .o_pressed          (o_pressed),
        .o_clicked          (o_clicked),
        .o_released         (o_released)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: check accepted transactions, stall at random.
    always @(posedge clk) begin : result_monitor
        t_knob_result got;
        if (rst_n && o_out_valid && !out_stall) begin
            got.step     = o_step;
            got.position = o_position;
            got.wrapped  = o_wrapped_position;
            got.pressed  = o_pressed;
            got.clicked  = o_clicked;
            got.released = o_released;
            sb.check_result(got);
        end
        out_stall <= !quiet && ($urandom_range(99) < 17);
    end

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_LIST_LENGTH)
            sb.list_length = data;
        else
            sb.debounce_ms = data;
    endtask

    // Offer one sample, return once it has been accepted; valid stays high.
    task automatic send_sample(logic a, logic b, logic sw, logic [31:0] now_ms);
        while (!quiet && $urandom_range(99) < 17) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_a     <= a;
        in_b     <= b;
        in_sw    <= sw;
        in_now   <= now_ms;
        @(posedge clk);
        while (o_in_stall)
            @(posedge clk);
        sb.note_sample(a, b, sw, now_ms);
    endtask

    // Let every result come home, then give the block time to go fully idle.
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic directed_items();
        int unsigned k;
        // start at rest, then one clockwise detent
        send_sample(1'b0, 1'b0, 1'b1, 32'd0);
        send_sample(1'b1, 1'b0, 1'b1, 32'd1);
        send_sample(1'b1, 1'b1, 1'b1, 32'd2);
        send_sample(1'b0, 1'b1, 1'b1, 32'd3);
        send_sample(1'b0, 1'b0, 1'b1, 32'd4);
        // two counterclockwise detents: position goes negative
        for (k = 0; k < 2; k++) begin
            send_sample(1'b0, 1'b1, 1'b1, 32'd5 + 4 * k);
            send_sample(1'b1, 1'b1, 1'b1, 32'd6 + 4 * k);
            send_sample(1'b1, 1'b0, 1'b1, 32'd7 + 4 * k);
            send_sample(1'b0, 1'b0, 1'b1, 32'd8 + 4 * k);
        end
        // press: raw change, then exactly at the threshold, then one past it
        send_sample(1'b0, 1'b0, 1'b0, 32'd100);
        send_sample(1'b0, 1'b0, 1'b0, 32'd150);
        send_sample(1'b0, 1'b0, 1'b0, 32'd151);
        // release across a timestamp wrap
        send_sample(1'b0, 1'b0, 1'b1, 32'hFFFF_FFE0);
        send_sample(1'b0, 1'b0, 1'b1, 32'h0000_0020);
        // rejected transition codes: double jumps
        send_sample(1'b1, 1'b1, 1'b1, 32'h0000_0021);
        send_sample(1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF);
        gray_idx   = 2'd0;
        switch_raw = 1'b1;
        stamp_ms   = 32'hFFFF_FFFF;
    endtask

    // Mostly clean quadrature runs with bouncing switch; some noise and skips.
    task automatic random_burst(int unsigned count, bit ccw_bias);
        int unsigned n;
        int unsigned pick;
        int unsigned run_left;
        bit          dir_cw;
        logic [1:0]  pair;
        run_left = 0;
        dir_cw   = 1'b1;
        for (n = 0; n < count; n++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(48, 1);
                dir_cw   = ccw_bias ? ($urandom_range(99) < 25) : ($urandom_range(1) == 1);
            end
            run_left--;

            pick = $urandom_range(99);
            if (pick < 72)
                gray_idx = dir_cw ? gray_idx + 2'd1 : gray_idx - 2'd1;
            else if (pick < 82)
                gray_idx = gray_idx;               // repeated pair
            else if (pick < 92)
                gray_idx = gray_idx + 2'd2;        // skipped state
            else
                gray_idx = 2'($urandom_range(3));  // noise
            pair = GRAY_SEQ[gray_idx*2 +: 2];

            if ($urandom_range(99) < 10)
                switch_raw = ~switch_raw;

            case ($urandom_range(9))
                0: ;
                1, 2, 3, 4: stamp_ms = stamp_ms + $urandom_range(3);
                5, 6, 7: stamp_ms = stamp_ms + $urandom_range(sb.debounce_ms + 2);
                8: stamp_ms = stamp_ms + sb.debounce_ms + $urandom_range(2);
                default: stamp_ms = stamp_ms + $urandom;
            endcase

            send_sample(pair[0], pair[1], switch_raw, stamp_ms);
        end
    endtask

    initial begin : stimulus
        int unsigned ph;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values
        directed_items();
        random_burst(300, 1'b0);

        for (ph = 0; ph < 5; ph++) begin
            drain_and_settle();
            quiet <= 1'b0;
            case (ph)
                0: begin
                    write_reg(REG_LIST_LENGTH, 16'd1);
                    write_reg(REG_DEBOUNCE_MS, 16'd0);
                end
                1: begin
                    write_reg(REG_LIST_LENGTH, 16'hFFFF);
                    write_reg(REG_DEBOUNCE_MS, 16'hFFFF);
                    quiet <= 1'b1;                      // no idling on either side
                end
                2: begin
                    write_reg(REG_LIST_LENGTH, 16'd0);  // zero modulus
                    write_reg(REG_DEBOUNCE_MS, 16'd1);
                end
                3: begin
                    write_reg(REG_LIST_LENGTH, 16'd7);
                    write_reg(REG_DEBOUNCE_MS, 16'd20);
                end
                default: begin
                    write_reg(REG_LIST_LENGTH, 16'($urandom_range(16'hFFFF, 1)));
                    write_reg(REG_DEBOUNCE_MS, 16'($urandom_range(300)));
                end
            endcase
            random_burst(320, ph[0]);
        end

        drain_and_settle();
        sb.finish_check();
        if (sb.failures == 0)
            $display("tb_quadrature_knob_decoder_core: PASS");
        else
            $display("tb_quadrature_knob_decoder_core: FAIL");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("tb_quadrature_knob_decoder_core: FAIL");
        $finish;
    end

endmodule

>>> quadrature_knob_decoder_core.f
sv/qkd_pkg.sv
sv/qkd_mod_unit.sv
sv/quadrature_knob_decoder_core.sv
sv/qkd_checker.sv
test/tb_quadrature_knob_decoder_core.sv
